// ===== rtl/uer_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Field widths, codes, lane and mode control structs and the tick to centimetre scaler.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int SENSOR_COUNT = 3;   // sensor lanes, 1 to 3
   localparam int ECHO_W       = 3;   // echo level bits on the request
   localparam int TIMER_W      = 16;
   localparam int CM_W         = 10;
   localparam int MODE_W       = 2;
   localparam int OUT_LANES    = 3;   // distance fields on the response

   // d * 5 / 58 / 10 (truncating) equals d / 116; done as a reciprocal multiply.
   // 36158 * 116 - 2^22 = 24, and 24 * 65535 < 2^22 keeps it exact for 16 bits.
   localparam logic [TIMER_W-1:0] RECIP_MULT  = 16'd36158;
   localparam int                 RECIP_SHIFT = 22;
   localparam int                 PROD_W      = 2 * TIMER_W;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_REFRESH = 1'b1;

   localparam logic [MODE_W-1:0] MODE_NONE = '0;

   localparam logic [CM_W-1:0] CM_MAX = 10'd564;

   typedef logic [CM_W-1:0]    cm_type;
   typedef logic [TIMER_W-1:0] ticks_type;
   typedef logic [MODE_W-1:0]  mode_type;

   typedef struct packed {
      logic advance;     // sample transfer moves into the lane stage
      logic prev_level;
      logic level;
   } lane_ctl_type;

   typedef struct packed {
      logic                    load;
      logic                    refresh;
      logic [SENSOR_COUNT-1:0] updated;
   } mode_ctl_type;

   function automatic cm_type ticks_to_cm(input ticks_type ticks);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(ticks) * PROD_W'(RECIP_MULT);
      return prod[RECIP_SHIFT +: CM_W];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/uer_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_ifs: request and response channels of the echo ranger
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface uer_req_if
   import uer_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                action;
   logic [ECHO_W-1:0]   echo_levels;
   logic [TIMER_W-1:0]  timer_count;

   modport source (output valid, output action, output echo_levels,
                   output timer_count, input ready);
   modport sink   (input valid, input action, input echo_levels,
                   input timer_count, output ready);
endinterface

interface uer_rsp_if
   import uer_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       proximity_mode;
   logic [CM_W-1:0]         left_cm;
   logic [CM_W-1:0]         center_cm;
   logic [CM_W-1:0]         right_cm;
   logic [OUT_LANES-1:0]    new_reading;

   modport source (output valid, output proximity_mode, output left_cm,
                   output center_cm, output right_cm, output new_reading,
                   input ready);
   modport sink   (input valid, input proximity_mode, input left_cm,
                   input center_cm, input right_cm, input new_reading,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/uer_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_lane: one sensor's echo timing lane
// Captures the start tick on a rising edge, scales the pulse on a falling edge.
// ----------------------------------------------------------------------------
module uer_lane
   import uer_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_ctl_type ctl,
   input  wire ticks_type    timer,
   output logic              fall,
   output cm_type            distance
);

   ticks_type start_ff;
   ticks_type duration;
   logic      rise;
   cm_type    dist_ff;

   assign rise     = ~ctl.prev_level & ctl.level;
   assign fall     = ctl.prev_level & ~ctl.level;
   assign duration = timer - start_ff;   // wraps modulo 2^16

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         dist_ff  <= '0;
      end else if (ctl.advance) begin
         if (rise) begin
            start_ff <= timer;
         end
         if (fall) begin
            dist_ff <= ticks_to_cm(duration);
         end
      end
   end

   assign distance = dist_ff;

endmodule
`default_nettype wire

// ===== rtl/uer_mode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_mode: proximity mode tracker
// Near checks against the threshold; last near sensor wins, refresh may clear.
// ----------------------------------------------------------------------------
module uer_mode
   import uer_pkg::*;
(
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mode_ctl_type                        ctl,
   input  wire logic [SENSOR_COUNT-1:0][CM_W-1:0]   distance,
   input  wire cm_type                              threshold,
   output mode_type                                 mode_next
);

   mode_type                mode_ff;
   mode_type                mode_in;
   logic [SENSOR_COUNT-1:0] near;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         near[i] = (distance[i] <= threshold);
      end
   end

   always_comb begin
      mode_in = mode_ff;
      if (ctl.refresh) begin
         if (near == '0) begin
            mode_in = MODE_NONE;
         end
      end else begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (ctl.updated[i] && near[i]) begin
               mode_in = MODE_W'(i + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (ctl.load) begin
         mode_ff <= mode_in;
      end
   end

   assign mode_next = mode_in;

endmodule
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Path: a request transfer loads the input register, then the lane stage
// and result registers in turn; the response is driven from the result register.
// Throughput: one item per cycle unless rsp_ch.ready is low; the lane
// stage holds the scaler multiply, the result stage the threshold compares
// and the mode priority. Reset (synchronous, active high): pipeline empty,
// start times, distances and mode cleared, near threshold set to 10 cm.
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: three-sensor echo pulse-width ranger
// Times echo pulses per sensor, converts to centimetres and tracks which
// sensor is near. One response per request.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
   import uer_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   uer_req_if.sink         req_ch,
   uer_rsp_if.source       rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [CM_W-1:0] csr_wr_data
);

   // --- configuration -------------------------------------------------------
   cm_type threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 10'd10;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // --- pipeline control ----------------------------------------------------
   // Each stage loads when the stage after it is empty or moving on, so
   // bubbles collapse and a waiting response does not block the front.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic out_load;
   logic s2_load;
   logic s1_load;

   assign out_load = s2_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign s2_load  = s1_valid_ff & (~s2_valid_ff | out_load);
   assign s1_load  = req_ch.valid & req_ch.ready;

   assign req_ch.ready = ~s1_valid_ff | s2_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (~s2_valid_ff | out_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (~rsp_valid_ff | rsp_ch.ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // --- input register --------------------------------------------------------
   logic              s1_action_ff;
   logic [ECHO_W-1:0] s1_levels_ff;
   ticks_type         s1_timer_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_action_ff <= req_ch.action;
         s1_levels_ff <= req_ch.echo_levels;
         s1_timer_ff  <= req_ch.timer_count;
      end
   end

   // --- sensor lanes ----------------------------------------------------------
   // Edges are taken against the levels of the last sample transfer; a
   // refresh leaves levels and start times alone.
   logic                              sample_adv;
   logic [SENSOR_COUNT-1:0]           prev_levels_ff;
   logic [SENSOR_COUNT-1:0]           lane_level;
   logic [SENSOR_COUNT-1:0]           lane_fall;
   logic [SENSOR_COUNT-1:0][CM_W-1:0] lane_dist;

   assign sample_adv = s2_load & (s1_action_ff == ACT_SAMPLE);

   for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
      lane_ctl_type lane_ctl;

      if (i < ECHO_W) begin : g_pin
         assign lane_level[i] = s1_levels_ff[i];
      end else begin : g_nopin
         assign lane_level[i] = 1'b0;   // no echo pin beyond the third sensor
      end

      assign lane_ctl.advance    = sample_adv;
      assign lane_ctl.prev_level = prev_levels_ff[i];
      assign lane_ctl.level      = lane_level[i];

      uer_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .timer    (s1_timer_ff),
         .fall     (lane_fall[i]),
         .distance (lane_dist[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
      end else if (sample_adv) begin
         prev_levels_ff <= lane_level;
      end
   end

   // --- lane stage register -----------------------------------------------------
   // Distances in the lanes already hold this item's updates while it sits here.
   logic                    s2_action_ff;
   logic [SENSOR_COUNT-1:0] s2_updated_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_action_ff  <= s1_action_ff;
         s2_updated_ff <= (s1_action_ff == ACT_SAMPLE) ? lane_fall : '0;
      end
   end

   // --- proximity mode ----------------------------------------------------------
   mode_ctl_type mode_ctl;
   mode_type     mode_next;

   assign mode_ctl.load    = out_load;
   assign mode_ctl.refresh = (s2_action_ff == ACT_REFRESH);
   assign mode_ctl.updated = s2_updated_ff;

   uer_mode u_mode (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mode_ctl),
      .distance  (lane_dist),
      .threshold (threshold_ff),
      .mode_next (mode_next)
   );

   // --- result register ---------------------------------------------------------
   logic [OUT_LANES-1:0][CM_W-1:0] out_cm;
   logic [OUT_LANES-1:0]           out_new;
   mode_type                       rsp_mode_ff;
   logic [OUT_LANES-1:0][CM_W-1:0] rsp_cm_ff;
   logic [OUT_LANES-1:0]           rsp_new_ff;

   for (genvar j = 0; j < OUT_LANES; j++) begin : g_out
      if (j < SENSOR_COUNT) begin : g_used
         assign out_cm[j]  = lane_dist[j];
         assign out_new[j] = s2_updated_ff[j];
      end else begin : g_unused
         assign out_cm[j]  = '0;
         assign out_new[j] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mode_ff <= mode_next;
         rsp_cm_ff   <= out_cm;
         rsp_new_ff  <= out_new;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.proximity_mode = rsp_mode_ff;
   assign rsp_ch.left_cm        = rsp_cm_ff[0];
   assign rsp_ch.center_cm      = rsp_cm_ff[1];
   assign rsp_ch.right_cm       = rsp_cm_ff[2];
   assign rsp_ch.new_reading    = rsp_new_ff;

`ifndef SYNTHESIS
   // Front only stalls when every stage holds an item.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline stage");

   // A refresh never reports a new reading.
   a_refresh_no_new: assert property (@(posedge clock) disable iff (reset)
      (out_load && s2_action_ff == ACT_REFRESH) |=> (rsp_new_ff == '0))
      else $error("refresh transfer flagged a new reading");

   // A refresh either clears the mode or leaves it as it was.
   a_refresh_mode: assert property (@(posedge clock) disable iff (reset)
      (out_load && s2_action_ff == ACT_REFRESH)
      |=> (rsp_mode_ff == MODE_NONE || rsp_mode_ff == $past(u_mode.mode_ff)))
      else $error("refresh set a non-zero mode");

   // Scaled distances stay within the 16-bit pulse range.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cm_ff[0] <= CM_MAX && rsp_cm_ff[1] <= CM_MAX
                        && rsp_cm_ff[2] <= CM_MAX))
      else $error("distance out of range");
`endif

endmodule
`default_nettype wire
